@@ rtl/core/entry_point_offset_translator_macros.svh @@
// Assertion macros shared by the entry-point offset translator checkers.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef ENTRY_POINT_OFFSET_TRANSLATOR_MACROS_SVH
`define ENTRY_POINT_OFFSET_TRANSLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ept_pkg.sv @@
// Shared types, codes and helpers for the entry-point offset translator.
// Has no dependencies; ept_core, the top and the checker import it.
package ept_pkg;

  // Widths fixed by the word formats.
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // Byte values that matter for emulation prevention.
  localparam logic [7:0] EPB_BYTE  = 8'h03;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Input word action codes.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COUNT = 1'b1;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] load_index;
    logic [POS_W-1:0] raw_offset;
    logic [7:0]       raw_byte;
    logic             last_byte;
  } ept_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic [POS_W-1:0] payload_offset;
    logic             run_end;
  } ept_result_t;

  typedef struct packed {
    logic [POS_W-1:0] start_offset;
    logic [CNT_W-1:0] offset_count;
  } ept_cfg_t;

  typedef struct packed {
    logic       drop;
    logic [1:0] zero_run;
  } ept_consume_t;

  // Judges one byte: a 0x03 after two zeros is dropped unless the following
  // byte is above 0x03. The zero-run count saturates at two.
  function automatic ept_consume_t ept_consume(logic [1:0] zero_run, logic [7:0] cur,
                                               logic has_next, logic [7:0] nxt);
    ept_consume_t r;
    r.drop = zero_run[1] && (cur == EPB_BYTE) && !(has_next && (nxt > EPB_BYTE));
    if (r.drop) begin
      r.zero_run = 2'd0;
    end else if (cur == ZERO_BYTE) begin
      r.zero_run = zero_run[1] ? 2'd2 : zero_run + 2'd1;
    end else begin
      r.zero_run = 2'd0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/ept_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
module ept_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/ept_core.sv @@
// Byte counting, offset matching and result sequencing for the translator.
// Depends on ept_pkg and holds the offset table in an ept_ram instance.
module ept_core import ept_pkg::*; #(
  parameter int unsigned MAX_OFFSETS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ept_cfg_t    cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ept_item_t   in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ept_result_t out_word_o
);

  localparam int unsigned SLOT_W = $clog2(MAX_OFFSETS + 1);
  localparam int unsigned ADDR_W = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
  localparam int unsigned CMP_W  = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_TAIL,
    S_FLUSH,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [POS_W-1:0]   raw_pos_q, raw_pos_d;
  logic [POS_W-1:0]   pay_pos_q, pay_pos_d;
  logic [POS_W-1:0]   raw_base_q, raw_base_d;
  logic [POS_W-1:0]   pay_base_q, pay_base_d;
  logic               started_q, started_d;
  logic [1:0]         zero_run_q, zero_run_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [7:0]         held_q, held_d;
  logic               held_valid_q, held_valid_d;
  logic               last_q, last_d;
  logic               pend_valid_q, pend_valid_d;
  ept_result_t        pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  ept_result_t        out_q, out_d;

  logic [SLOT_W-1:0]  active_cnt;
  logic [SLOT_W-1:0]  slot_next;
  logic               in_fire;
  logic               out_free;
  logic               ram_we;
  logic               ram_re;
  logic [POS_W-1:0]   ram_rdata;
  ept_consume_t       cons;
  logic [POS_W-1:0]   step_raw;
  logic [POS_W-1:0]   step_pay;
  logic [POS_W-1:0]   now_raw;
  logic [POS_W-1:0]   now_pay;
  logic               start_hit;
  logic [POS_W-1:0]   rel_raw;
  logic [POS_W-1:0]   rel_pay;

  // Offsets in use, saturated to the table depth.
  always_comb begin
    if (CMP_W'(cfg_i.offset_count) > CMP_W'(MAX_OFFSETS)) begin
      active_cnt = SLOT_W'(MAX_OFFSETS);
    end else begin
      active_cnt = SLOT_W'(cfg_i.offset_count);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign slot_next  = slot_q + SLOT_W'(1);

  // Table loads are taken only while idle, so a read never overlaps a write.
  assign ram_we = in_fire && (in_word_i.action == ACT_LOAD) &&
                  (CMP_W'(in_word_i.load_index) < CMP_W'(MAX_OFFSETS));
  assign ram_re = (state_q == S_READ);

  ept_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_OFFSETS)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ADDR_W'(in_word_i.load_index)),
    .wdata_i (in_word_i.raw_offset),
    .re_i    (ram_re),
    .raddr_i (ADDR_W'(slot_q)),
    .rdata_o (ram_rdata)
  );

  // The held byte is judged against the arriving byte, or with no byte after
  // it when the final byte is retired.
  assign cons     = ept_consume(zero_run_q, held_q, (state_q == S_IDLE), in_word_i.raw_byte);
  assign step_raw = raw_pos_q + POS_W'(1);
  assign step_pay = pay_pos_q + POS_W'(!cons.drop);
  assign now_raw  = held_valid_q ? step_raw : raw_pos_q;
  assign now_pay  = held_valid_q ? step_pay : pay_pos_q;
  assign start_hit = !started_q && (now_pay == cfg_i.start_offset);
  assign rel_raw  = raw_pos_q - raw_base_q;
  assign rel_pay  = pay_pos_q - pay_base_q;

  // Next-state logic for the sequencer and the stream counters.
  always_comb begin
    state_d      = state_q;
    raw_pos_d    = raw_pos_q;
    pay_pos_d    = pay_pos_q;
    raw_base_d   = raw_base_q;
    pay_base_d   = pay_base_q;
    started_d    = started_q;
    zero_run_d   = zero_run_q;
    slot_d       = slot_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    last_d       = last_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_word_i.action == ACT_BYTE)) begin
          if (held_valid_q) begin
            raw_pos_d  = step_raw;
            pay_pos_d  = step_pay;
            zero_run_d = cons.zero_run;
          end
          if (start_hit) begin
            raw_base_d = now_raw;
            pay_base_d = now_pay;
            started_d  = 1'b1;
          end
          held_d       = in_word_i.raw_byte;
          held_valid_d = 1'b1;
          last_d       = in_word_i.last_byte;
          if ((started_q || start_hit) && (slot_q < active_cnt)) begin
            state_d = S_READ;
          end else begin
            state_d = S_TAIL;
          end
        end
      end

      S_READ: begin
        state_d = S_CMP;
      end

      // A match becomes the pending word; the previous pending word goes out
      // with run_end clear since another result follows it.
      S_CMP: begin
        if (ram_rdata == rel_raw) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_valid_d          = 1'b1;
            pend_d.result_index   = IDX_W'(slot_q);
            pend_d.payload_offset = rel_pay;
            pend_d.run_end        = 1'b0;
            slot_d                = slot_next;
            state_d = (slot_next < active_cnt) ? S_READ : S_TAIL;
          end
        end else begin
          state_d = S_TAIL;
        end
      end

      // The final byte is judged with nothing after it before the flush.
      S_TAIL: begin
        if (last_q) begin
          raw_pos_d  = step_raw;
          pay_pos_d  = step_pay;
          zero_run_d = cons.zero_run;
          state_d    = S_FLUSH;
        end else begin
          state_d = S_DONE;
        end
      end

      // Remaining offsets all report the final payload count.
      S_FLUSH: begin
        if (slot_q < active_cnt) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_valid_d          = 1'b1;
            pend_d.result_index   = IDX_W'(slot_q);
            pend_d.payload_offset = rel_pay;
            pend_d.run_end        = 1'b0;
            slot_d                = slot_next;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      // The last result of the word carries run_end; a final byte then
      // clears the stream state for the next NAL unit.
      S_DONE: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d     = 1'b1;
            out_d           = pend_q;
            out_d.run_end   = 1'b1;
            pend_valid_d    = 1'b0;
          end
          if (last_q) begin
            raw_pos_d    = '0;
            pay_pos_d    = '0;
            raw_base_d   = '0;
            pay_base_d   = '0;
            started_d    = 1'b0;
            zero_run_d   = 2'd0;
            slot_d       = '0;
            held_d       = ZERO_BYTE;
            held_valid_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, stream counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      raw_pos_q    <= '0;
      pay_pos_q    <= '0;
      raw_base_q   <= '0;
      pay_base_q   <= '0;
      started_q    <= 1'b0;
      zero_run_q   <= 2'd0;
      slot_q       <= '0;
      held_q       <= ZERO_BYTE;
      held_valid_q <= 1'b0;
      last_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      raw_pos_q    <= raw_pos_d;
      pay_pos_q    <= pay_pos_d;
      raw_base_q   <= raw_base_d;
      pay_base_q   <= pay_base_d;
      started_q    <= started_d;
      zero_run_q   <= zero_run_d;
      slot_q       <= slot_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      last_q       <= last_d;
      pend_valid_q <= pend_valid_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/core/entry_point_offset_translator.sv @@
// Entry-point offset translator: turns a slice's cumulative entry-point
// offsets, counted in raw NAL bytes, into offsets in payload bytes with
// emulation prevention bytes removed. Load words write the offset table
// (one word per cycle while idle); byte words then stream the NAL unit one
// raw byte per word. A byte word that reaches no offset occupies the block
// from its acceptance through the tail and done states; every offset table
// entry read from the offset RAM adds a read issue and a compare against
// the registered read data, and the final byte adds the judgement of the
// held byte and a flush step per remaining offset. The sequence stalls
// only while the output register is full and the consumer holds off.
// Configuration writes are taken in any cycle.
module entry_point_offset_translator import ept_pkg::*; #(
  parameter int unsigned MAX_OFFSETS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [POS_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ept_item_t            in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ept_result_t          out_word_o
);

  ept_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_OFFSET: cfg_q.start_offset <= cfg_data_i;
        CFG_OFFSET_COUNT: cfg_q.offset_count <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  ept_core #(
    .MAX_OFFSETS (MAX_OFFSETS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/core/ept_checker.sv @@
// Port-level checks for the entry-point offset translator, bound to the top.
// Depends on ept_pkg and the shared assertion macro header.
`include "entry_point_offset_translator_macros.svh"

module ept_checker import ept_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input ept_item_t   in_word_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input ept_result_t out_word_o
);

  // A result word waiting for the consumer keeps its value.
  `EPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o), "result word changed while stalled")

  // A byte word always keeps the block busy for at least the next cycle.
  `EPT_ASSERT_NEXT(a_byte_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (in_word_i.action == ACT_BYTE), !in_ready_o, "byte word did not occupy the block")

  // A table load finishes in its own cycle.
  `EPT_ASSERT_NEXT(a_load_ready, clk_i, rst_ni, in_valid_i && in_ready_o && (in_word_i.action == ACT_LOAD), in_ready_o, "block busy after a table load")

  // Configuration writes are never held off.
  `EPT_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "configuration write stalled")

endmodule

bind entry_point_offset_translator ept_checker u_ept_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

@@ tb/entry_point_offset_translator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for entry_point_offset_translator: streams offset tables and NAL bytes.
// Keeps its own translation model and checks every result word in order; needs ept_pkg and the RTL.
module entry_point_offset_translator_tb;
  import ept_pkg::*;

  localparam int unsigned SLOTS           = 32;
  localparam int unsigned ITEM_TARGET     = 170;
  localparam int unsigned SETTLE_CYCLES   = 120;
  localparam int unsigned HOLD_OFF_CYCLES = 200;

  typedef logic [7:0] byte_list_t [$];

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [POS_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  ept_item_t            in_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  ept_result_t          out_word_o;

  // Translation model state, kept apart from the block.
  logic [POS_W-1:0] offset_slots [SLOTS];
  logic [POS_W-1:0] start_setting;
  logic [CNT_W-1:0] count_setting;
  logic [POS_W-1:0] raw_pos;
  logic [POS_W-1:0] payload_pos;
  logic [POS_W-1:0] raw_base;
  logic [POS_W-1:0] payload_base;
  logic             started;
  logic [1:0]       zero_run;
  logic [CNT_W-1:0] next_slot;
  logic [7:0]       held_byte;
  logic             held_valid;
  ept_result_t      expected_translations [$];
  ept_result_t      want;

  // Run bookkeeping.
  int unsigned errors;
  int unsigned words_sent;
  int unsigned units_sent;
  int unsigned results_checked;
  int unsigned epb_removed;
  bit          gaps_on;
  bit          hold_off_request;
  int unsigned hold_count;

  entry_point_offset_translator #(
    .MAX_OFFSETS(SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  // Stream counters return to zero after reset and after every final byte.
  function automatic void clear_stream();
    raw_pos      = '0;
    payload_pos  = '0;
    raw_base     = '0;
    payload_base = '0;
    started      = 1'b0;
    zero_run     = 2'd0;
    next_slot    = '0;
    held_byte    = 8'h00;
    held_valid   = 1'b0;
  endfunction

  // Judges one raw byte: a 0x03 after two zeros is removed unless the next byte is above 0x03.
  function automatic void judge_byte(logic [7:0] cur, logic has_next, logic [7:0] nxt);
    if (zero_run >= 2'd2 && cur == EPB_BYTE && !(has_next && nxt > EPB_BYTE)) begin
      zero_run = 2'd0;
      raw_pos++;
      epb_removed++;
    end else begin
      if (cur == ZERO_BYTE) begin
        zero_run = (zero_run >= 2'd2) ? 2'd2 : zero_run + 2'd1;
      end else begin
        zero_run = 2'd0;
      end
      raw_pos++;
      payload_pos++;
    end
  endfunction

  // Queues the translation of the current slot at the current payload position.
  function automatic void add_translation();
    ept_result_t r;
    r.result_index   = next_slot[IDX_W-1:0];
    r.payload_offset = payload_pos - payload_base;
    r.run_end        = 1'b0;
    expected_translations.push_back(r);
    next_slot++;
  endfunction

  // Works out every result word caused by one accepted input word.
  function automatic void translate_word(ept_item_t w);
    int unsigned      queued;
    logic [CNT_W-1:0] limit;
    queued = expected_translations.size();
    limit  = (count_setting > SLOTS) ? CNT_W'(SLOTS) : count_setting;
    if (w.action == ACT_LOAD) begin
      offset_slots[w.load_index] = w.raw_offset;
    end else begin
      if (held_valid) begin
        judge_byte(held_byte, 1'b1, w.raw_byte);
      end
      if (!started && payload_pos == start_setting) begin
        raw_base     = raw_pos;
        payload_base = payload_pos;
        started      = 1'b1;
      end
      while (started && next_slot < limit &&
             (raw_pos - raw_base) == offset_slots[next_slot[IDX_W-1:0]]) begin
        add_translation();
      end
      held_byte  = w.raw_byte;
      held_valid = 1'b1;
      // The final byte is judged with nothing after it, then the rest is flushed.
      if (w.last_byte) begin
        judge_byte(held_byte, 1'b0, ZERO_BYTE);
        while (next_slot < limit) begin
          add_translation();
        end
        clear_stream();
      end
    end
    if (expected_translations.size() > queued) begin
      expected_translations[expected_translations.size() - 1].run_end = 1'b1;
    end
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 70) begin
      return 0;
    end
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Bytes biased toward zero runs and 0x03 so emulation prevention is hit often.
  function automatic logic [7:0] pick_nal_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      return ZERO_BYTE;
    end else if (roll < 55) begin
      return EPB_BYTE;
    end else if (roll < 70) begin
      return 8'($urandom_range(1, 4));
    end
    return 8'($urandom);
  endfunction

  function automatic ept_item_t load_word(logic [IDX_W-1:0] slot, logic [POS_W-1:0] offset);
    ept_item_t w;
    w.action     = ACT_LOAD;
    w.load_index = slot;
    w.raw_offset = offset;
    w.raw_byte   = 8'($urandom);
    w.last_byte  = 1'($urandom);
    return w;
  endfunction

  function automatic ept_item_t byte_word(logic [7:0] value, logic last);
    ept_item_t w;
    w.action     = ACT_BYTE;
    w.load_index = IDX_W'($urandom);
    w.raw_offset = $urandom;
    w.raw_byte   = value;
    w.last_byte  = last;
    return w;
  endfunction

  // Offers one input word and updates the model when it is taken.
  task automatic send_word(ept_item_t w);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    translate_word(w);
    words_sent++;
  endtask

  // Sends a whole NAL unit; the last word carries the end mark.
  task automatic send_unit(byte_list_t nal);
    int unsigned k;
    for (k = 0; k < nal.size(); k++) begin
      send_word(byte_word(nal[k], k == nal.size() - 1));
    end
    units_sent++;
  endtask

  // Waits until every result is in and the block has had time to finish silent work.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_translations.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [POS_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_START_OFFSET) begin
      start_setting = data;
    end else begin
      count_setting = data[CNT_W-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One unit with a fresh, mostly ascending offset table; noisy units use plain random
  // bytes and slip a stray table load into the byte stream.
  task automatic random_unit(int unsigned n_slots, bit noisy);
    int unsigned      k;
    int unsigned      len;
    int unsigned      stray_at;
    logic [POS_W-1:0] offset;
    offset = '0;
    for (k = 0; k < n_slots; k++) begin
      offset += $urandom_range(0, 3);
      send_word(load_word(IDX_W'(k), ($urandom_range(0, 19) == 0) ? $urandom : offset));
    end
    len      = $urandom_range(1, 16);
    stray_at = noisy ? $urandom_range(0, len - 1) : len;
    for (k = 0; k < len; k++) begin
      if (k == stray_at) begin
        send_word(load_word(IDX_W'($urandom), $urandom_range(0, 20)));
      end
      send_word(byte_word(noisy ? 8'($urandom) : pick_nal_byte(), k == len - 1));
    end
    units_sent++;
  endtask

  // With translation disabled, bytes and loads produce nothing.
  task automatic test_disabled_translation();
    byte_list_t nal;
    send_word(load_word(5'd0, 32'h0000_0000));
    send_word(load_word(5'd31, 32'hFFFF_FFFF));
    nal = '{8'h00, 8'h00, 8'h03, 8'h01};
    send_unit(nal);
    drain_block();
  endtask

  // Removed and kept 0x03 bytes, a saturated zero run, two offsets at one position,
  // a trailing 0x03 removed at the end, and an unreachable offset flushed.
  task automatic test_emulation_prevention();
    byte_list_t nal;
    write_register(CFG_START_OFFSET, 32'd0);
    write_register(CFG_OFFSET_COUNT, 32'd4);
    send_word(load_word(5'd0, 32'd0));
    send_word(load_word(5'd1, 32'd3));
    send_word(load_word(5'd2, 32'd3));
    send_word(load_word(5'd3, 32'hFFFF_FFFF));
    nal = '{8'hFF, 8'h00, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h03, 8'h04,
            8'h00, 8'h00, 8'h00, 8'h03};
    send_unit(nal);
    drain_block();
  endtask

  // A start position never reached leaves the bases at zero; a one-byte unit too.
  task automatic test_start_never_reached();
    byte_list_t nal;
    write_register(CFG_START_OFFSET, 32'hFFFF_FFFF);
    write_register(CFG_OFFSET_COUNT, 32'd2);
    nal = '{8'h00, 8'h00, 8'h03};
    send_unit(nal);
    nal = '{8'h5A};
    send_unit(nal);
    drain_block();
  endtask

  // An offset count above the table size is clipped; all slots are loaded and read.
  task automatic test_offset_count_saturation();
    int unsigned      k;
    logic [POS_W-1:0] offset;
    byte_list_t       nal;
    gaps_on = 1'b0;
    write_register(CFG_START_OFFSET, $urandom_range(0, 3));
    write_register(CFG_OFFSET_COUNT, 32'h0000_003F);
    offset = '0;
    for (k = 0; k < SLOTS; k++) begin
      offset += $urandom_range(0, 1);
      send_word(load_word(IDX_W'(k), offset));
    end
    for (k = 0; k < 24; k++) begin
      nal.push_back(pick_nal_byte());
    end
    send_unit(nal);
    drain_block();
    gaps_on = 1'b1;
  endtask

  // Phases with random settings, each a few units, some of them noisy.
  task automatic test_random_units();
    int unsigned n_slots;
    int unsigned k;
    while (words_sent < ITEM_TARGET - 60) begin
      n_slots = $urandom_range(1, 8);
      write_register(CFG_START_OFFSET, $urandom_range(0, 4));
      write_register(CFG_OFFSET_COUNT, n_slots);
      for (k = 0; k < 3; k++) begin
        random_unit(n_slots, $urandom_range(0, 3) == 0);
      end
      drain_block();
    end
  endtask

  // The receiver holds off for a long stretch while units keep coming.
  task automatic test_back_pressure();
    write_register(CFG_START_OFFSET, 32'd0);
    write_register(CFG_OFFSET_COUNT, 32'd8);
    hold_off_request = 1'b1;
    random_unit(8, 1'b0);
    random_unit(8, 1'b0);
    drain_block();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_request) begin
        out_ready_i <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++) begin
          @(negedge clk_i);
        end
        hold_off_request = 1'b0;
        out_ready_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 99) < 25) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : $urandom_range(9, 39))
          @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every accepted result word is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_translations.size() == 0) begin
        $display("%0t: result with none expected: index %0d offset %0d end %0b", $time,
                 out_word_o.result_index, out_word_o.payload_offset, out_word_o.run_end);
        errors++;
      end else begin
        want = expected_translations.pop_front();
        results_checked++;
        if (out_word_o.result_index !== want.result_index ||
            out_word_o.payload_offset !== want.payload_offset ||
            out_word_o.run_end !== want.run_end) begin
          $display("%0t: mismatch expected index %0d offset %0d end %0b", $time,
                   want.result_index, want.payload_offset, want.run_end);
          $display("%0t:          actual   index %0d offset %0d end %0b", $time,
                   out_word_o.result_index, out_word_o.payload_offset, out_word_o.run_end);
          errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_START_OFFSET;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    in_word_i        = '0;
    out_ready_i      = 1'b0;
    gaps_on          = 1'b1;
    hold_off_request = 1'b0;
    start_setting    = '0;
    count_setting    = '0;
    foreach (offset_slots[k]) begin
      offset_slots[k] = '0;
    end
    clear_stream();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_disabled_translation();
    test_emulation_prevention();
    test_start_never_reached();
    test_offset_count_saturation();
    test_random_units();
    test_back_pressure();

    $display("Covered %0d input words in %0d NAL units with %0d emulation prevention bytes;",
             words_sent, units_sent, epb_removed);
    $display("%0d translated offsets compared, %0d errors.", results_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, sized for every word flushing a full table under the longest receiver stalls.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d results outstanding", $time,
             expected_translations.size());
    $display("simulation failed");
    $finish;
  end

endmodule
